// File: hdl/scell_pkg.sv
`timescale 1ns / 1ps

package scell_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int ACC_WIDTH_DEF   = 32;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CLASS_COUNT_RESET = 5'd2;

  localparam int EV_W   = 24;
  localparam int UNC_W  = 16;
  localparam int CNT_IN_W = 16;
  localparam int WIN_W  = 4;
  localparam int WGT_W  = 32;

  // multiplier: 32 x 16, product 48 bits
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // divider: quotient bits and remainder width
  localparam int QUO_W = 17;
  localparam int DEN_W = WGT_W + 1;
  localparam int NUM_W = 50;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  typedef struct packed {
    logic [EV_W-1:0]     evidence;
    logic [UNC_W-1:0]    uncertainty;
    logic [CNT_IN_W-1:0] sample_count;
    logic                with_uncertainty;
  } in_word_t;

  typedef struct packed {
    logic [WIN_W-1:0] winning_class;
    logic             occupied;
    logic [UNC_W-1:0] uncertainty_average;
    logic [WGT_W-1:0] total_weight;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/scell_ram.sv
`timescale 1ns / 1ps

module scell_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/semantic_cell_evidence_update_top.sv
`timescale 1ns / 1ps

// One semantic map cell. Evidence words arrive one class at a time in class
// order on the input channel (in_valid / in_stall / in_data); each word adds
// its evidence to a saturating per-class accumulator held in a small RAM.
// The word for the last class of a vector produces one result word on the
// output channel (out_valid / out_stall / out_data): first class with the
// greatest evidence, occupied flag, uncertainty average and total weight.
// cfg_write / cfg_data set the number of classes per vector.
// Steps: a word that is not the last class passes through a RAM read, then
// an add and write back. The last class adds an emit step, and when the
// uncertainty is folded into a non-empty stored weight, it also takes two
// passes through the shared 32x16 multiplier, one sum, 17 restoring divide
// steps (one quotient bit a cycle) and a store. in_stall is high while a word
// is being worked on.
// The result sits in an output register, so the next vector starts while it
// waits; if the receiver still stalls when the following result is ready,
// the block holds in its emit step. Reset (synchronous) clears the
// accumulators through per-class valid bits, the stores and the class count
// (back to 2).

module semantic_cell_evidence_update_top
  import scell_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int POS_W = $clog2(MAX_CLASSES);
  localparam int CMP_W = (POS_W >= CFG_W) ? POS_W + 2 : CFG_W + 1;
  localparam int IDX_EXT_W = POS_W + WIN_W;

  state_t state, state_next;

  logic [CFG_W-1:0]       class_count;
  logic [POS_W-1:0]       class_position;
  logic [ACC_WIDTH-1:0]   best_value;
  logic [POS_W-1:0]       best_index;
  logic [UNC_W-1:0]       average_store;
  logic [WGT_W-1:0]       weight_store;
  logic [MAX_CLASSES-1:0] class_valid;

  in_word_t               item;
  logic [MUL_P_W-1:0]     mul_reg;
  logic [NUM_W-1:0]       rem;
  logic [NUM_W-1:0]       dsh;
  logic [QUO_W-1:0]       quot;
  logic [DIV_CNT_W-1:0]   div_cnt;

  // ram
  logic                   ram_we;
  logic [ACC_WIDTH-1:0]   ram_rd_data;

  // position and vector length
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       n_eff;
  logic [POS_W-1:0]       pos_eff;
  logic                   last_class;

  // accumulate
  logic [ACC_WIDTH-1:0]   acc_old;
  logic [ACC_WIDTH:0]     acc_sum;
  logic [ACC_WIDTH-1:0]   acc_new;

  // shared arithmetic
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     mul_p;
  logic [DEN_W-1:0]       den;
  logic                   div_ge;

  logic                   out_free;
  logic [IDX_EXT_W-1:0]   best_ext;

  scell_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (MAX_CLASSES)
  ) u_evidence_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pos_eff),
    .wr_data (acc_new),
    .rd_addr (pos_eff),
    .rd_data (ram_rd_data)
  );

  // effective class count: 0 acts as 1, clamp to MAX_CLASSES
  always_comb begin
    cnt_ext = CMP_W'(class_count);
    if (cnt_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(MAX_CLASSES)) begin
      n_eff = CMP_W'(MAX_CLASSES);
    end else begin
      n_eff = cnt_ext;
    end
    if (CMP_W'(class_position) >= CMP_W'(MAX_CLASSES)) begin
      pos_eff = POS_W'(MAX_CLASSES - 1);
    end else begin
      pos_eff = class_position;
    end
    last_class = (CMP_W'(pos_eff) + CMP_W'(1)) >= n_eff;
  end

  always_comb begin
    acc_old = class_valid[pos_eff] ? ram_rd_data : '0;
    acc_sum = (ACC_WIDTH+1)'(acc_old) + (ACC_WIDTH+1)'(item.evidence);
    acc_new = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];
  end

  assign den    = DEN_W'(weight_store) + DEN_W'(item.sample_count);
  assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign div_ge = rem >= dsh;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    mul_a      = weight_store;
    mul_b      = average_store;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        ram_we = 1'b1;
        if (!last_class) begin
          state_next = ST_IDLE;
        end else if (item.with_uncertainty && weight_store != '0) begin
          state_next = ST_MUL_OLD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL_OLD: begin
        state_next = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        mul_a      = MUL_A_W'(item.sample_count);
        mul_b      = item.uncertainty;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(QUO_W - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count    <= CLASS_COUNT_RESET;
      class_position <= '0;
      best_value     <= '0;
      best_index     <= '0;
      average_store  <= '0;
      weight_store   <= '0;
      class_valid    <= '0;
      out_valid      <= 1'b0;
      div_cnt        <= '0;
    end else begin
      if (cfg_write) begin
        class_count <= cfg_data;
      end
      // load a new word, or drop the one just taken
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACCUM: begin
          class_valid[pos_eff] <= 1'b1;
          if (pos_eff == '0 || acc_new > best_value) begin
            best_value <= acc_new;
            best_index <= pos_eff;
          end
          if (last_class) begin
            class_position <= '0;
            // empty stored weight: take the new value directly
            if (item.with_uncertainty && weight_store == '0) begin
              average_store <= item.uncertainty;
              weight_store  <= WGT_W'(item.sample_count);
            end
          end else begin
            class_position <= pos_eff + POS_W'(1);
          end
        end
        ST_SUM: begin
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        ST_STORE: begin
          average_store <= quot[QUO_W-1] ? '1 : quot[UNC_W-1:0];
          weight_store  <= den[DEN_W-1] ? '1 : den[WGT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign best_ext = IDX_EXT_W'(best_index);

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_data;
    end
    unique case (state)
      ST_MUL_OLD: begin
        mul_reg <= mul_p;
      end
      ST_MUL_NEW: begin
        // old product plus half the divisor for round to nearest
        rem     <= NUM_W'(mul_reg) + NUM_W'(den[DEN_W-1:1]);
        mul_reg <= mul_p;
      end
      ST_SUM: begin
        rem  <= rem + NUM_W'(mul_reg);
        dsh  <= NUM_W'({den, {(QUO_W-1){1'b0}}});
        quot <= '0;
      end
      ST_DIV: begin
        if (div_ge) begin
          rem <= rem - dsh;
        end
        quot <= {quot[QUO_W-2:0], div_ge};
        dsh  <= dsh >> 1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data.winning_class       <= best_ext[WIN_W-1:0];
          out_data.occupied            <= best_index != '0;
          out_data.uncertainty_average <= average_store;
          out_data.total_weight        <= weight_store;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: test/tb_semantic_cell_evidence_update_top.sv
`timescale 1ns / 1ps

module tb_semantic_cell_evidence_update_top;
  import scell_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int NUM_PHASES = 7;
  localparam int NUM_ROWS = 18;

  // one row of the directed table: input word, pinned flag, pinned result
  typedef struct packed {
    in_word_t  word;
    logic      pinned;
    out_word_t result;
  } stim_row_t;

  // evidence, uncertainty, sample count, with_uncertainty | pinned |
  // winning class, occupied, average, total weight (class count stays at 2)
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    {24'h000000, 16'h1234, 16'h0000, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    // all zero: class 0 wins, empty weight takes the uncertainty as is
    {24'h000000, 16'hABCD, 16'h0000, 1'b1, 1'b1, 4'h0, 1'b0, 16'hABCD, 32'h0},
    {24'h000005, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    // tie goes to the lower class; no uncertainty update
    {24'h000005, 16'h0000, 16'h0000, 1'b0, 1'b1, 4'h0, 1'b0, 16'hABCD, 32'h0},
    {24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h000001, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 4'h1, 1'b1, 16'hFFFF, 32'h0000FFFF},
    {24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    // halfway average rounds up
    {24'hFFFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 4'h1, 1'b1, 16'h8000, 32'h0001FFFE},
    {24'h000001, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h000000, 16'h0001, 16'h0001, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'hAAAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h555555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h555555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'hAAAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h123456, 16'hFFFF, 16'h0001, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h000000, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h800000, 16'h8000, 16'h8000, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0},
    {24'h7FFFFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0}
  };

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_data;
  logic             cfg_write;
  logic [CFG_W-1:0] cfg_data;

  // pinned result travels with the word on offer
  logic             pin_valid;
  out_word_t        pin_result;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // cell model state
  logic [ACC_WIDTH_DEF-1:0] class_acc [MAX_CLASSES_DEF];
  int unsigned              vec_pos;
  logic [ACC_WIDTH_DEF-1:0] lead_value;
  logic [WIN_W-1:0]         lead_class;
  logic [UNC_W-1:0]         unc_avg;
  logic [WGT_W-1:0]         weight_sum;
  logic [CFG_W-1:0]         classes_cfg;

  out_word_t due_results [$];

  semantic_cell_evidence_update_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch %s at %0t: got %0h, want %0h", what, $time, got, want);
  endtask

  // Add one evidence word to the cell; on the last class, fold the
  // uncertainty and give back the result word.
  task automatic cell_update(input in_word_t w, output bit emits, output out_word_t r);
    int unsigned              n;
    int unsigned              p;
    logic [ACC_WIDTH_DEF:0]   sum;
    logic [63:0]              den;
    logic [63:0]              num;
    logic [63:0]              quo;
    n = (classes_cfg == 0) ? 1 : ((classes_cfg > MAX_CLASSES_DEF) ? MAX_CLASSES_DEF
                                                                 : classes_cfg);
    p = (vec_pos >= MAX_CLASSES_DEF) ? MAX_CLASSES_DEF - 1 : vec_pos;
    sum = {1'b0, class_acc[p]} + (ACC_WIDTH_DEF+1)'(w.evidence);
    if (sum[ACC_WIDTH_DEF])
      sum = {1'b0, {ACC_WIDTH_DEF{1'b1}}};
    class_acc[p] = sum[ACC_WIDTH_DEF-1:0];
    if (p == 0 || class_acc[p] > lead_value) begin
      lead_value = class_acc[p];
      lead_class = p[WIN_W-1:0];
    end
    r = '0;
    emits = (p + 1 >= n);
    if (!emits) begin
      vec_pos = p + 1;
    end else begin
      vec_pos = 0;
      if (w.with_uncertainty) begin
        if (weight_sum == 0) begin
          unc_avg = w.uncertainty;
          weight_sum = WGT_W'(w.sample_count);
        end else begin
          den = 64'(weight_sum) + 64'(w.sample_count);
          num = 64'(weight_sum) * 64'(unc_avg) + 64'(w.sample_count) * 64'(w.uncertainty);
          quo = (num + den / 2) / den;
          unc_avg = (quo > 64'hFFFF) ? 16'hFFFF : quo[UNC_W-1:0];
          // the stored weight saturates, the divide above does not
          weight_sum = (den > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : den[WGT_W-1:0];
        end
      end
      r.winning_class = lead_class;
      r.occupied = (lead_class != 0);
      r.uncertainty_average = unc_avg;
      r.total_weight = weight_sum;
    end
  endtask

  // compare the delivered word first, then take in the accepted one
  always @(posedge clk) begin
    out_word_t due;
    out_word_t predicted;
    bit        emits;
    if (!rst) begin
      if (cfg_write)
        classes_cfg = cfg_data;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_data), 64'h0);
        end else begin
          due = due_results.pop_front();
          if (out_data.winning_class !== due.winning_class)
            report_mismatch("winning_class", 64'(out_data.winning_class),
                            64'(due.winning_class));
          if (out_data.occupied !== due.occupied)
            report_mismatch("occupied", 64'(out_data.occupied), 64'(due.occupied));
          if (out_data.uncertainty_average !== due.uncertainty_average)
            report_mismatch("uncertainty_average", 64'(out_data.uncertainty_average),
                            64'(due.uncertainty_average));
          if (out_data.total_weight !== due.total_weight)
            report_mismatch("total_weight", 64'(out_data.total_weight),
                            64'(due.total_weight));
        end
      end
      if (in_valid && !in_stall) begin
        cell_update(in_data, emits, predicted);
        if (emits)
          due_results.push_back(pin_valid ? pin_result : predicted);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w, input logic pinned, input out_word_t r);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= w;
    pin_valid  <= pinned;
    pin_result <= r;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0)
      @(negedge clk);
    // a word with no result may still be in the block
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [EV_W-1:0] pick_evidence(bit heavy);
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (heavy)
      return (sel < 95) ? {EV_W{1'b1}} : EV_W'($urandom);
    if (sel < 15)
      return '0;
    if (sel < 30)
      return {EV_W{1'b1}};
    if (sel < 50)
      return EV_W'($urandom_range(3, 0));
    return EV_W'($urandom);
  endfunction

  function automatic logic [15:0] pick_word16();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 15)
      return 16'hFFFF;
    if (sel < 35)
      return 16'($urandom_range(3, 0));
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned phase_cfg [NUM_PHASES]   = '{4, 16, 3, 0, 31, 7, 1};
    int unsigned phase_items [NUM_PHASES] = '{202, 169, 200, 60, 64, 150, 280};
    int unsigned phase_idle [NUM_PHASES]  = '{0, 60, 0, 22, 0, 22, 0};
    int unsigned phase_stall [NUM_PHASES] = '{0, 0, 60, 22, 0, 22, 0};
    in_word_t    w;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    pin_valid = 1'b0;
    pin_result = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    mismatch_count = 0;
    for (int i = 0; i < MAX_CLASSES_DEF; i++)
      class_acc[i] = '0;
    vec_pos = 0;
    lead_value = '0;
    lead_class = '0;
    unc_avg = '0;
    weight_sum = '0;
    classes_cfg = CLASS_COUNT_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part runs at the reset class count
    for (int i = 0; i < NUM_ROWS; i++)
      send_word(DIR_ROWS[i].word, DIR_ROWS[i].pinned, DIR_ROWS[i].result);
    in_valid <= 1'b0;
    pin_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // hold until every result is back, then reprogramme the class count
      wait_drained();
      cfg_write <= 1'b1;
      cfg_data  <= CFG_W'(phase_cfg[p]);
      @(negedge clk);
      cfg_write <= 1'b0;
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (phase_cfg[p] > MAX_CLASSES_DEF)
        hold_cycles = HOLD_OFF_CYCLES;
      for (int i = 0; i < phase_items[p]; i++) begin
        w.evidence = pick_evidence(p == NUM_PHASES - 1);
        w.uncertainty = pick_word16();
        w.sample_count = pick_word16();
        w.with_uncertainty = ($urandom_range(3, 0) != 0);
        send_word(w, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
